// ===== rtl/lts_pkg.sv =====
// Package with the shared types, sizes and helpers of the threshold square search.
`timescale 1ns / 1ps
package lts_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int DIM_W      = 7;
    localparam int IDX_W      = 6;
    localparam int ADDR_W     = 12;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int VALUE_CAP  = 65;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PASS,
        ST_DRAIN,
        ST_DECIDE,
        ST_DONE
    } t_state;

    // Per-cell control travelling alongside the store read.
    typedef struct packed {
        logic valid;
        logic first_row;
        logic first_col;
        logic pad;
    } t_sweep_ctl;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/lts_cell.sv =====
// One column cell of the chain: holds a square size and a column run, passed on each shift.
`timescale 1ns / 1ps
module lts_cell
    import lts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIM_W-1:0] i_sq,
    input  logic [DIM_W-1:0] i_crun,
    output logic [DIM_W-1:0] o_sq,
    output logic [DIM_W-1:0] o_crun
);

    logic [DIM_W-1:0] r_sq;
    logic [DIM_W-1:0] r_crun;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= i_sq;
            r_crun <= i_crun;
        end
    end

    assign o_sq   = r_sq;
    assign o_crun = r_crun;

endmodule

// ===== rtl/lts_dp.sv =====
// Largest-square recurrence over a chain of column cells, one grid cell per cycle.
`timescale 1ns / 1ps
module lts_dp
    import lts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  t_sweep_ctl       i_ctl,
    input  logic [DIM_W-1:0] i_k,
    input  logic [DIM_W-1:0] i_value,
    output logic [DIM_W-1:0] o_best
);

    logic [DIM_W-1:0] w_sq   [MAX_COLS+1];
    logic [DIM_W-1:0] w_crun [MAX_COLS+1];
    logic [DIM_W-1:0] r_diag;
    logic [DIM_W-1:0] r_rrun;
    logic [DIM_W-1:0] r_best;
    logic [DIM_W-1:0] n_d;
    logic [DIM_W-1:0] n_rrun;
    logic [DIM_W-1:0] n_crun;
    logic [DIM_W-1:0] w_rr_prev;
    logic [DIM_W-1:0] w_min;
    logic             w_qual;

    // The chain is one full row long, so its tail holds the previous row's column.
    genvar g;
    generate
        for (g = 0; g < MAX_COLS; g++) begin : g_cell
            lts_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (i_ctl.valid),
                .i_sq   (w_sq[g]),
                .i_crun (w_crun[g]),
                .o_sq   (w_sq[g+1]),
                .o_crun (w_crun[g+1])
            );
        end
    endgenerate

    always_comb begin
        w_qual    = !i_ctl.pad && (i_value >= i_k);
        w_rr_prev = i_ctl.first_col ? '0 : r_rrun;
        w_min     = r_diag;
        if (w_rr_prev < w_min) begin
            w_min = w_rr_prev;
        end
        if (w_crun[MAX_COLS] < w_min) begin
            w_min = w_crun[MAX_COLS];
        end
        if (!w_qual) begin
            n_d    = '0;
            n_rrun = '0;
            n_crun = '0;
        end else begin
            if (i_ctl.first_row || i_ctl.first_col) begin
                n_d = DIM_W'(1);
            end else begin
                n_d = w_min + DIM_W'(1);
            end
            n_rrun = w_rr_prev + DIM_W'(1);
            n_crun = i_ctl.first_row ? DIM_W'(1) : w_crun[MAX_COLS] + DIM_W'(1);
        end
    end

    assign w_sq[0]   = n_d;
    assign w_crun[0] = n_crun;

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_diag <= w_sq[MAX_COLS];
            r_rrun <= n_rrun;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best <= '0;
        end else if (i_ctl.valid && n_d > r_best) begin
            r_best <= n_d;
        end
    end

    assign o_best = r_best;

endmodule

// ===== rtl/largest_threshold_square_search.sv =====
// Top level: grid store, binary search sequencer and stream ports.
// Loading takes one word per cycle; only the last cell starts a search.
// Each trial side sweeps rows x 64 cell slots, one per cycle, followed by the setup,
// drain and decision states; the search runs at most 7 trials, then the done state
// loads the result register once it is empty. No word is taken while searching.
// Synchronous active-low reset clears control state; the grid store is not cleared.
`timescale 1ns / 1ps
module largest_threshold_square_search
    import lts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [DIM_W-1:0] i_cfg_data,
    input  logic [31:0]      s_axis_tdata,   // [31:0] cell_value
    input  logic             s_axis_tlast,   // last_cell
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] largest_side, [7] zero
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready
);

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;
    localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(MAX_COLS - 1);

    t_state r_state, n_state;

    logic [DIM_W-1:0]  r_rows_cfg, r_cols_cfg;
    logic [ADDR_W-1:0] r_load_pos;
    logic [DIM_W-1:0]  r_store [STORE_DEPTH];
    logic [DIM_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]  r_i, r_j;
    logic [ADDR_W-1:0] r_addr;
    logic [DIM_W-1:0]  r_k, r_low, r_high, r_best_side;
    logic              r_out_valid;
    logic [DIM_W-1:0]  r_out_side;
    t_sweep_ctl        r_ctl, n_ctl;

    logic [DIM_W-1:0]  w_rows, w_cols, w_rows_m1, w_mid, w_best, w_stored;
    logic              w_in_acc, w_pad, w_exists, w_last_slot;
    logic              w_clear, w_issue;

    assign w_rows    = clamp_dim(r_rows_cfg, DIM_W'(MAX_ROWS));
    assign w_cols    = clamp_dim(r_cols_cfg, DIM_W'(MAX_COLS));
    assign w_rows_m1 = w_rows - DIM_W'(1);
    assign w_mid     = r_low + ((r_high - r_low) >> 1);
    assign w_pad     = {1'b0, r_j} >= w_cols;
    assign w_exists  = w_best >= r_k;
    assign w_last_slot = (r_i == w_rows_m1[IDX_W-1:0]) && (r_j == LAST_COL);
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (s_axis_tdata[31]) begin
            w_stored = '0;
        end else if (s_axis_tdata > 32'(VALUE_CAP)) begin
            w_stored = DIM_W'(VALUE_CAP);
        end else begin
            w_stored = s_axis_tdata[DIM_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_in_acc && s_axis_tlast) n_state = ST_SETUP;
            ST_SETUP:  n_state = (r_low <= r_high) ? ST_PASS : ST_DONE;
            ST_PASS:   if (w_last_slot) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = (!w_exists && r_k == '0) ? ST_DONE : ST_SETUP;
            ST_DONE:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        w_clear       = 1'b0;
        w_issue       = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_SETUP: w_clear = 1'b1;
            ST_PASS:  w_issue = 1'b1;
            default:  ;
        endcase
        n_ctl.valid     = w_issue;
        n_ctl.first_row = (r_i == '0);
        n_ctl.first_col = (r_j == '0);
        n_ctl.pad       = w_pad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rows_cfg <= DIM_W'(1);
            r_cols_cfg <= DIM_W'(1);
            r_load_pos <= '0;
            r_ctl      <= '0;
        end else begin
            r_state <= n_state;
            r_ctl   <= n_ctl;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data;
                    CFG_COLS: r_cols_cfg <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (w_in_acc) begin
                r_load_pos <= s_axis_tlast ? '0 : r_load_pos + ADDR_W'(1);
            end
        end
    end

    // Grid store: one write port for loading, one registered read port for the sweep.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_store[r_load_pos] <= w_stored;
        end
        r_rd_data <= r_store[r_addr];
    end

    // Sweep counters and search bounds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= '0;
            r_high      <= '0;
            r_best_side <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_addr      <= '0;
        end else begin
            if (w_in_acc && s_axis_tlast) begin
                r_low       <= '0;
                r_high      <= (w_rows < w_cols) ? w_rows : w_cols;
                r_best_side <= '0;
            end
            if (r_state == ST_SETUP) begin
                r_k    <= w_mid;
                r_i    <= '0;
                r_j    <= '0;
                r_addr <= '0;
            end
            if (w_issue) begin
                r_j <= r_j + IDX_W'(1);
                if (r_j == LAST_COL) begin
                    r_i <= r_i + IDX_W'(1);
                end
                if (!w_pad) begin
                    r_addr <= r_addr + ADDR_W'(1);
                end
            end
            if (r_state == ST_DECIDE) begin
                if (w_exists) begin
                    if (r_k > r_best_side) begin
                        r_best_side <= r_k;
                    end
                    r_low <= r_k + DIM_W'(1);
                end else if (r_k != '0) begin
                    r_high <= r_k - DIM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_side <= r_best_side;
        end
    end

    lts_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_ctl   (r_ctl),
        .i_k     (r_k),
        .i_value (r_rd_data),
        .o_best  (w_best)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_side};

    a_block_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> !s_axis_tready)
        else $error("word accepted right after the last cell");

    a_side_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_side <= DIM_W'(MAX_ROWS))
        else $error("found side out of range");

    a_sweep_only_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid |-> ($past(r_state) == ST_PASS))
        else $error("sweep slot issued outside a pass");

endmodule
